// File: rtl/cspc_pkg.sv
`timescale 1ns / 1ps

package cspc_pkg;

  // Width of the internal wrapping millisecond time.
  localparam int unsigned TimeWidth = 32;
  // The time field of an item is always 32 bits wide.
  localparam int unsigned InTimeWidth = 32;
  // Wide enough to hold both the input time and the internal time.
  localparam int unsigned TimePadWidth = (TimeWidth > InTimeWidth) ? TimeWidth : InTimeWidth;

  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned CfgDataWidth = 16;

  localparam logic [CfgIdxWidth-1:0] CfgPowerHold = 2'd0;
  localparam logic [CfgIdxWidth-1:0] CfgStableHigh = 2'd1;
  localparam logic [CfgIdxWidth-1:0] CfgToggleWindow = 2'd2;
  localparam logic [CfgIdxWidth-1:0] CfgDetectLevel = 2'd3;

  localparam logic [15:0] PowerHoldReset = 16'd1000;
  localparam logic [15:0] StableHighReset = 16'd400;
  localparam logic [15:0] ToggleWindowReset = 16'd1500;

  typedef logic [TimeWidth-1:0] time_t;

  typedef enum logic [1:0] {
    StNoPower   = 2'd0,
    StCharging  = 2'd1,
    StFull      = 2'd2,
    StNoBattery = 2'd3
  } charger_state_e;

  typedef struct packed {
    logic [15:0] power_hold_ms;
    logic [15:0] steady_ms;
    logic [15:0] toggle_window_ms;
    logic        detect_active_level;
  } cfg_t;

  // Bit 0 up: state, power_ok, is_charging, is_full, battery_missing.
  typedef struct packed {
    logic           battery_missing;
    logic           is_full;
    logic           is_charging;
    logic           power_ok;
    charger_state_e charger_state;
  } status_t;

  typedef struct packed {
    status_t status;
    logic    changed;
  } result_t;

endpackage

// File: rtl/cspc_in_if.sv
`timescale 1ns / 1ps

interface cspc_in_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 detect_level;
  logic                                 full_level;
  logic [cspc_pkg::InTimeWidth-1:0]     time_ms;

  modport source (output valid, output detect_level, output full_level, output time_ms,
                  input ready);
  modport sink (input valid, input detect_level, input full_level, input time_ms,
                output ready);
endinterface

// File: rtl/cspc_out_if.sv
`timescale 1ns / 1ps

interface cspc_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] charger_state;
  logic       power_ok;
  logic       is_charging;
  logic       is_full;
  logic       battery_missing;
  logic       changed;

  modport source (output valid, output charger_state, output power_ok,
                  output is_charging, output is_full, output battery_missing,
                  output changed, input ready);
  modport sink (input valid, input charger_state, input power_ok,
                input is_charging, input is_full, input battery_missing,
                input changed, output ready);
endinterface

// File: rtl/cspc_core.sv
`timescale 1ns / 1ps

// Pin history and classification. The result is combinational from the
// current item and the stored history; the history moves on when upd_i is high.
module cspc_core (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cspc_pkg::cfg_t        cfg_i,
  input  logic                  upd_i,
  input  logic                  detect_level_i,
  input  logic                  full_level_i,
  input  cspc_pkg::time_t       now_i,
  output cspc_pkg::result_t     result_o
);

  cspc_pkg::time_t det_run_start_q, det_run_start_d;
  cspc_pkg::time_t ful_run_start_q, ful_run_start_d;
  cspc_pkg::time_t det_last_q, det_last_d;
  cspc_pkg::time_t ful_last_q, ful_last_d;
  cspc_pkg::time_t pwr_last_q, pwr_last_d;
  logic det_run_valid_q, ful_run_valid_q;
  logic det_seen_q, det_seen_d;
  logic ful_seen_q, ful_seen_d;
  logic pwr_seen_q, pwr_seen_d;
  cspc_pkg::status_t held_q, status;

  logic det, ful;
  cspc_pkg::time_t age_pwr, age_det_run, age_ful_run, age_det, age_ful;
  cspc_pkg::time_t hold_w, stable_w, toggle_w;
  logic power, det_stable, ful_stable, alt, nobat;
  cspc_pkg::charger_state_e state;

  assign det = (detect_level_i == cfg_i.detect_active_level);
  assign ful = full_level_i;

  always_comb begin
    det_run_start_d = det ? (det_run_valid_q ? det_run_start_q : now_i) : '0;
    ful_run_start_d = ful ? (ful_run_valid_q ? ful_run_start_q : now_i) : '0;
    det_last_d = det ? now_i : det_last_q;
    ful_last_d = ful ? now_i : ful_last_q;
    pwr_last_d = (det || ful) ? now_i : pwr_last_q;
    det_seen_d = det_seen_q || det;
    ful_seen_d = ful_seen_q || ful;
    pwr_seen_d = pwr_seen_q || det || ful;
  end

  // Ages wrap modulo the time width.
  assign age_pwr = now_i - pwr_last_d;
  assign age_det_run = now_i - det_run_start_d;
  assign age_ful_run = now_i - ful_run_start_d;
  assign age_det = now_i - det_last_d;
  assign age_ful = now_i - ful_last_d;

  assign hold_w = cspc_pkg::TimeWidth'(cfg_i.power_hold_ms);
  assign stable_w = cspc_pkg::TimeWidth'(cfg_i.steady_ms);
  assign toggle_w = cspc_pkg::TimeWidth'(cfg_i.toggle_window_ms);

  always_comb begin
    power = pwr_seen_d && (age_pwr <= hold_w);
    det_stable = det && (age_det_run >= stable_w);
    ful_stable = ful && (age_ful_run >= stable_w);
    alt = power && det_seen_d && ful_seen_d && (age_det <= toggle_w) && (age_ful <= toggle_w);
    nobat = alt && !det_stable && !ful_stable;

    if (!power) begin
      state = cspc_pkg::StNoPower;
    end else if (ful_stable && !nobat) begin
      state = cspc_pkg::StFull;
    end else if (nobat) begin
      state = cspc_pkg::StNoBattery;
    end else begin
      state = cspc_pkg::StCharging;
    end

    status.charger_state = state;
    status.power_ok = power;
    status.is_charging = (state == cspc_pkg::StCharging) || (state == cspc_pkg::StNoBattery);
    status.is_full = (state == cspc_pkg::StFull);
    status.battery_missing = nobat;
  end

  assign result_o.status = status;
  assign result_o.changed = (status != held_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      det_run_start_q <= '0;
      ful_run_start_q <= '0;
      det_last_q <= '0;
      ful_last_q <= '0;
      pwr_last_q <= '0;
      det_run_valid_q <= 1'b0;
      ful_run_valid_q <= 1'b0;
      det_seen_q <= 1'b0;
      ful_seen_q <= 1'b0;
      pwr_seen_q <= 1'b0;
      held_q <= '0;
    end else if (upd_i) begin
      det_run_start_q <= det_run_start_d;
      ful_run_start_q <= ful_run_start_d;
      det_last_q <= det_last_d;
      ful_last_q <= ful_last_d;
      pwr_last_q <= pwr_last_d;
      det_run_valid_q <= det;
      ful_run_valid_q <= ful;
      det_seen_q <= det_seen_d;
      ful_seen_q <= ful_seen_d;
      pwr_seen_q <= pwr_seen_d;
      held_q <= status;
    end
  end

endmodule

// File: rtl/charger_status_pin_classifier.sv
`timescale 1ns / 1ps

// Channel   Direction  Payload
// in_i      sink       detect_level, full_level, time_ms[31:0]
// out_o     source     charger_state[1:0], power_ok, is_charging, is_full,
//                      battery_missing, changed
// cfg_*     write      cfg_idx_i selects the register, cfg_data_i[15:0] is the value
//
// Every item passes through the input register and then the result register.
// While the output is not stalled, a new item is accepted in every cycle,
// so the sustained rate is one item per cycle, set by the single classification
// pass between the two registers. Reset clears the pin history, the held status
// and the configuration to its defaults. A stalled result register holds its item
// while the input register can still take one more; input ready drops only when
// both are full.
module charger_status_pin_classifier (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  cspc_in_if.sink                              in_i,
  cspc_out_if.source                           out_o,
  input  logic                                 cfg_we_i,
  input  logic [cspc_pkg::CfgIdxWidth-1:0]     cfg_idx_i,
  input  logic [cspc_pkg::CfgDataWidth-1:0]    cfg_data_i
);

  // Configuration registers.
  cspc_pkg::cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.power_hold_ms <= cspc_pkg::PowerHoldReset;
      cfg_q.steady_ms <= cspc_pkg::StableHighReset;
      cfg_q.toggle_window_ms <= cspc_pkg::ToggleWindowReset;
      cfg_q.detect_active_level <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        cspc_pkg::CfgPowerHold: cfg_q.power_hold_ms <= cfg_data_i;
        cspc_pkg::CfgStableHigh: cfg_q.steady_ms <= cfg_data_i;
        cspc_pkg::CfgToggleWindow: cfg_q.toggle_window_ms <= cfg_data_i;
        cspc_pkg::CfgDetectLevel: cfg_q.detect_active_level <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  // Input register. It moves on whenever the result register is free or is
  // being emptied in the same cycle.
  logic s1_valid_q;
  logic s1_det_q, s1_ful_q;
  cspc_pkg::time_t s1_now_q;
  logic s1_adv;
  logic in_acc;
  logic [cspc_pkg::TimePadWidth-1:0] time_pad;

  logic out_valid_q;
  cspc_pkg::result_t out_q;
  cspc_pkg::result_t result;

  assign s1_adv = !out_valid_q || out_o.ready;
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_acc = in_i.valid && in_i.ready;

  // The input time enters the internal width zero-extended or cut down.
  assign time_pad = cspc_pkg::TimePadWidth'(in_i.time_ms);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_det_q <= in_i.detect_level;
      s1_ful_q <= in_i.full_level;
      s1_now_q <= time_pad[cspc_pkg::TimeWidth-1:0];
    end
  end

  // Classification pass; the pin history advances as the item leaves the
  // input register, so the next item always sees this one's effect.
  cspc_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .upd_i          (s1_valid_q && s1_adv),
    .detect_level_i (s1_det_q),
    .full_level_i   (s1_ful_q),
    .now_i          (s1_now_q),
    .result_o       (result)
  );

  // Result register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_valid_q && s1_adv) begin
      out_q <= result;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.charger_state = out_q.status.charger_state;
  assign out_o.power_ok = out_q.status.power_ok;
  assign out_o.is_charging = out_q.status.is_charging;
  assign out_o.is_full = out_q.status.is_full;
  assign out_o.battery_missing = out_q.status.battery_missing;
  assign out_o.changed = out_q.changed;

  // An accepted item always lands in the input register.
  assert property (@(posedge clk_i) disable iff (!rst_ni) in_acc |=> s1_valid_q)
    else $error("accepted item did not reach the input register");

  // With both registers full and the output stalled, no item may enter.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |-> !in_i.ready)
    else $error("input accepted while the pipeline is full");

  // A missing battery is only reported with power and the no-battery state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.battery_missing) |->
      (out_o.power_ok && (out_o.charger_state == cspc_pkg::StNoBattery)))
    else $error("battery missing flag inconsistent with state");

  // The full flag tracks the full state exactly.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> (out_o.is_full == (out_o.charger_state == cspc_pkg::StFull)))
    else $error("full flag inconsistent with state");

endmodule
